### hdl/htcb_pkg.sv
// types and constants shared by the host/target command bridge
`default_nettype none
package htcb_pkg;

  localparam int CoreW    = 5;
  localparam int MemW     = 20;
  localparam int AddrW    = 40;
  localparam int DataW    = 64;
  localparam int ReqAddrW = 43;
  localparam int SeqW     = 8;
  localparam int SizeW    = 12;
  localparam int RegNumW  = 20;

  // event kinds
  localparam logic [1:0] OP_HOST       = 2'd0;
  localparam logic [1:0] OP_CREG_REPLY = 2'd1;
  localparam logic [1:0] OP_MEM_REPLY  = 2'd2;

  // packet commands
  localparam logic [2:0] CMD_MEM_READ   = 3'd0;
  localparam logic [2:0] CMD_MEM_WRITE  = 3'd1;
  localparam logic [2:0] CMD_READ_CREG  = 3'd2;
  localparam logic [2:0] CMD_WRITE_CREG = 3'd3;

  // target request kinds
  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_MEM  = 2'd1;
  localparam logic [1:0] REQ_CREG = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  // configuration register index (byte address bit 2)
  localparam logic REG_CORE_COUNT = 1'b0;
  localparam logic REG_MEM_SIZE   = 1'b1;

  // system register space
  localparam logic [RegNumW-1:0] SYS_CORE_ID   = 20'hFFFFF;
  localparam logic [RegNumW-1:0] SYS_REG_CORES = 20'd0;
  localparam logic [RegNumW-1:0] SYS_REG_MEM   = 20'd1;

  localparam logic [SizeW-1:0] ONE_DWORD = 12'd1;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [2:0]       command;
    logic [SeqW-1:0]  packet_seq;
    logic [SizeW-1:0] packet_size;
    logic [AddrW-1:0] packet_addr;
    logic [DataW-1:0] data;
  } item_t;

  typedef struct packed {
    logic                ack_valid;
    logic [SeqW-1:0]     ack_seq;
    logic                ack_has_data;
    logic [DataW-1:0]    ack_data;
    logic [1:0]          req_kind;
    logic [ReqAddrW-1:0] req_addr;
    logic [DataW-1:0]    req_data;
    logic                req_write;
    logic                target_in_reset;
    logic [1:0]          status;
  } result_t;

  typedef struct packed {
    logic            waiting_target;
    logic [SeqW-1:0] expected_seq;
    logic [SeqW-1:0] pending_seq;
    logic            reset_flag;
  } bridge_state_t;

  typedef struct packed {
    logic [CoreW-1:0] core_count;
    logic [MemW-1:0]  mem_size_mib;
  } cfg_t;

endpackage
`default_nettype wire

### hdl/htcb_decode.sv
// packet check, decode and local answers for one item
`default_nettype none
module htcb_decode #(
  parameter int unsigned DATA_ALIGN     = 8,
  parameter int unsigned RESET_REG_NUM  = 1922,
  parameter int unsigned HARTID_REG_NUM = 3856
) (
  input  htcb_pkg::item_t         item,
  input  htcb_pkg::bridge_state_t state,
  input  htcb_pkg::cfg_t          cfg,
  output htcb_pkg::bridge_state_t state_next,
  output htcb_pkg::result_t       result
);
  import htcb_pkg::*;

  logic [RegNumW-1:0]  core_id;
  logic [RegNumW-1:0]  reg_num;
  logic [ReqAddrW-1:0] byte_addr;
  logic                packet_ok;
  logic                is_write;
  logic                taken;

  assign core_id   = item.packet_addr[AddrW-1:RegNumW];
  assign reg_num   = item.packet_addr[RegNumW-1:0];
  assign byte_addr = ReqAddrW'({{(ReqAddrW-AddrW){1'b0}}, item.packet_addr}
                     * ReqAddrW'(DATA_ALIGN));
  assign packet_ok = (item.packet_seq == state.expected_seq)
                     && (item.packet_size == ONE_DWORD) && !item.command[2];
  assign is_write  = (item.command == CMD_MEM_WRITE) || (item.command == CMD_WRITE_CREG);

  always_comb begin
    result     = '0;
    state_next = state;
    taken      = 1'b0;
    case (item.opcode) inside
      OP_HOST: begin
        if (state.waiting_target) begin
          result.status = ST_BUSY;
        end else if (!packet_ok) begin
          result.status = ST_BAD;
        end else if ((item.command == CMD_MEM_READ) || (item.command == CMD_MEM_WRITE)) begin
          taken            = 1'b1;
          result.req_kind  = REQ_MEM;
          result.req_addr  = byte_addr;
          result.req_write = is_write;
          result.req_data  = is_write ? item.data : '0;
          if (is_write) begin
            result.ack_valid = 1'b1;
            result.ack_seq   = state.expected_seq;
          end else begin
            state_next.pending_seq    = state.expected_seq;
            state_next.waiting_target = 1'b1;
          end
        end else if (core_id == SYS_CORE_ID) begin
          taken               = 1'b1;
          result.ack_valid    = 1'b1;
          result.ack_seq      = state.expected_seq;
          result.ack_has_data = 1'b1;
          if (reg_num == SYS_REG_CORES) begin
            result.ack_data = DataW'(cfg.core_count);
          end else if (reg_num == SYS_REG_MEM) begin
            result.ack_data = DataW'(cfg.mem_size_mib);
          end else begin
            result.ack_data = '1;
          end
        end else if (core_id >= RegNumW'(cfg.core_count)) begin
          result.status = ST_BAD;
        end else if (is_write && (reg_num == RegNumW'(RESET_REG_NUM))) begin
          taken               = 1'b1;
          result.ack_valid    = 1'b1;
          result.ack_seq      = state.expected_seq;
          result.ack_has_data = 1'b1;
          result.ack_data     = DataW'(state.reset_flag);
          if (!item.data[0]) begin
            state_next.reset_flag = 1'b0;
          end
        end else if (reg_num == RegNumW'(HARTID_REG_NUM)) begin
          taken               = 1'b1;
          result.ack_valid    = 1'b1;
          result.ack_seq      = state.expected_seq;
          result.ack_has_data = 1'b1;
          result.ack_data     = DataW'(1);
        end else begin
          taken                     = 1'b1;
          result.req_kind           = REQ_CREG;
          result.req_addr           = ReqAddrW'(reg_num);
          result.req_write          = is_write;
          result.req_data           = is_write ? item.data : '0;
          state_next.pending_seq    = state.expected_seq;
          state_next.waiting_target = 1'b1;
        end
      end
      OP_CREG_REPLY, OP_MEM_REPLY: begin
        if (state.waiting_target) begin
          result.ack_valid          = 1'b1;
          result.ack_seq            = state.pending_seq;
          result.ack_has_data       = 1'b1;
          result.ack_data           = item.data;
          state_next.waiting_target = 1'b0;
        end
      end
      default: begin
        result.status = ST_BAD;
      end
    endcase
    if (taken) begin
      state_next.expected_seq = state.expected_seq + SeqW'(1);
    end
    result.target_in_reset = state_next.reset_flag;
  end

endmodule
`default_nettype wire

### hdl/host_target_command_bridge_top.sv
// host/target command bridge top level: input register, decode, result register, config
//
// channel  | handshake                  | payload
// ---------+----------------------------+-----------------------------------------------
// item     | item_valid / item_stall    | opcode command packet_seq packet_size
//          |                            | packet_addr data
// result   | result_valid / result_stall| ack_* req_* target_in_reset status
// config   | psel penable pwrite pready | paddr pwdata prdata (0: core_count, 4: mem_size)
//
// one item per cycle unless results stall; results are registered from the input register
// the decode stage sets the rate: it reads and updates the bridge state in the same cycle
// rst resets the bridge state (reset flag set), both valid flags and the config registers
// a stalled result holds the result register; the input register still takes one more item
`default_nettype none
module host_target_command_bridge_top #(
  parameter int unsigned DATA_ALIGN     = 8,
  parameter int unsigned RESET_REG_NUM  = 1922,
  parameter int unsigned HARTID_REG_NUM = 3856
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // item channel
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [2:0]  command,
  input  wire logic [htcb_pkg::SeqW-1:0]  packet_seq,
  input  wire logic [htcb_pkg::SizeW-1:0] packet_size,
  input  wire logic [htcb_pkg::AddrW-1:0] packet_addr,
  input  wire logic [htcb_pkg::DataW-1:0] data,
  // result channel
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic             ack_valid,
  output logic [htcb_pkg::SeqW-1:0]     ack_seq,
  output logic             ack_has_data,
  output logic [htcb_pkg::DataW-1:0]    ack_data,
  output logic [1:0]       req_kind,
  output logic [htcb_pkg::ReqAddrW-1:0] req_addr,
  output logic [htcb_pkg::DataW-1:0]    req_data,
  output logic             req_write,
  output logic             target_in_reset,
  output logic [1:0]       status
);
  import htcb_pkg::*;

  cfg_t          cfg;
  bridge_state_t state;
  bridge_state_t state_next;
  item_t         in_item;
  logic          in_full;
  result_t       dec_result;
  result_t       result;
  logic          item_take;
  logic          advance;
  logic          cfg_write;

  // config registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.core_count   <= CoreW'(1);
      cfg.mem_size_mib <= '0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_CORE_COUNT: cfg.core_count   <= pwdata[CoreW-1:0];
        REG_MEM_SIZE:   cfg.mem_size_mib <= pwdata[MemW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CORE_COUNT: prdata = 32'(cfg.core_count);
      REG_MEM_SIZE:   prdata = 32'(cfg.mem_size_mib);
      default:        prdata = '0;
    endcase
  end

  // handshake
  assign advance    = in_full && !(result_valid && result_stall);
  assign item_stall = in_full && result_valid && result_stall;
  assign item_take  = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      in_item.opcode      <= opcode;
      in_item.command     <= command;
      in_item.packet_seq  <= packet_seq;
      in_item.packet_size <= packet_size;
      in_item.packet_addr <= packet_addr;
      in_item.data        <= data;
    end
  end

  htcb_decode #(
    .DATA_ALIGN     (DATA_ALIGN),
    .RESET_REG_NUM  (RESET_REG_NUM),
    .HARTID_REG_NUM (HARTID_REG_NUM)
  ) u_decode (
    .item       (in_item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (dec_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.waiting_target <= 1'b0;
      state.expected_seq   <= '0;
      state.pending_seq    <= '0;
      state.reset_flag     <= 1'b1;
      result_valid         <= 1'b0;
    end else if (advance) begin
      state        <= state_next;
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= dec_result;
    end
  end

  assign ack_valid       = result.ack_valid;
  assign ack_seq         = result.ack_seq;
  assign ack_has_data    = result.ack_has_data;
  assign ack_data        = result.ack_data;
  assign req_kind        = result.req_kind;
  assign req_addr        = result.req_addr;
  assign req_data        = result.req_data;
  assign req_write       = result.req_write;
  assign target_in_reset = result.target_in_reset;
  assign status          = result.status;

  // the target reset flag is only ever cleared
  a_reset_flag_never_sets: assert property (@(posedge clk) disable iff (rst)
    !$rose(state.reset_flag))
    else $error("target reset flag set again");

  // a refused item carries neither ack nor request
  a_refused_is_silent: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != ST_OK) |->
      !result.ack_valid && (result.req_kind == REQ_NONE))
    else $error("refused item produced ack or request");

  // an ack without data only answers a memory write
  a_dataless_ack_is_mem_write: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.ack_valid && !result.ack_has_data |->
      (result.req_kind == REQ_MEM) && result.req_write)
    else $error("ack without data not from memory write");

  // a read request to the target leaves the bridge waiting
  a_read_req_waits: assert property (@(posedge clk) disable iff (rst)
    advance && (dec_result.req_kind != REQ_NONE) && !dec_result.req_write |=>
      state.waiting_target && !result.ack_valid)
    else $error("read request issued without waiting on target");

endmodule
`default_nettype wire

### sim/host_target_command_bridge_top_tb.sv
// testbench for the host/target command bridge: random and directed items, scoreboard check
`default_nettype none
module host_target_command_bridge_top_tb;
  import htcb_pkg::*;

  localparam int DataAlign    = 8;
  localparam int ResetRegNum  = 1922;
  localparam int HartIdRegNum = 3856;

  localparam logic [1:0] OpUndef    = 2'd3;
  localparam logic [2:0] CmdUnknown = 3'd4;
  localparam logic [2:0] CmdLast    = 3'd7;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                item_valid = 1'b0;
  logic                item_stall;
  logic [1:0]          opcode = '0;
  logic [2:0]          command = '0;
  logic [SeqW-1:0]     packet_seq = '0;
  logic [SizeW-1:0]    packet_size = '0;
  logic [AddrW-1:0]    packet_addr = '0;
  logic [DataW-1:0]    data = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic                ack_valid;
  logic [SeqW-1:0]     ack_seq;
  logic                ack_has_data;
  logic [DataW-1:0]    ack_data;
  logic [1:0]          req_kind;
  logic [ReqAddrW-1:0] req_addr;
  logic [DataW-1:0]    req_data;
  logic                req_write;
  logic                target_in_reset;
  logic [1:0]          status;

  logic steady = 1'b0;

  host_target_command_bridge_top #(
    .DATA_ALIGN(DataAlign),
    .RESET_REG_NUM(ResetRegNum),
    .HARTID_REG_NUM(HartIdRegNum)
  ) dut (.*);

  always #1 clk = ~clk;

  class bridge_scoreboard;
    logic            awaiting_reply = 1'b0;
    logic [SeqW-1:0] next_seq = '0;
    logic [SeqW-1:0] reply_seq = '0;
    logic            hold_reset = 1'b1;
    logic [CoreW-1:0] cores = 5'd1;
    logic [MemW-1:0]  mem_mib = '0;
    result_t         due_results[$];
    int              mismatches = 0;

    function void set_register(logic idx, logic [31:0] value);
      if (idx == REG_CORE_COUNT) begin
        cores = value[CoreW-1:0];
      end else begin
        mem_mib = value[MemW-1:0];
      end
    endfunction

    function void note_event(item_t it);
      result_t            want;
      logic [RegNumW-1:0] core;
      logic [RegNumW-1:0] regno;
      logic               ok;
      logic               answer;
      logic               with_data;
      logic [DataW-1:0]   word;
      want = '0;
      ok = 1'b0;
      answer = 1'b0;
      with_data = 1'b0;
      word = '0;
      core = it.packet_addr[AddrW-1:RegNumW];
      regno = it.packet_addr[RegNumW-1:0];
      if (it.opcode == OP_HOST) begin
        if (awaiting_reply) begin
          want.status = ST_BUSY;
        end else if (it.packet_seq != next_seq || it.packet_size != ONE_DWORD ||
                     it.command > CMD_WRITE_CREG) begin
          want.status = ST_BAD;
        end else if (it.command == CMD_MEM_READ || it.command == CMD_MEM_WRITE) begin
          ok = 1'b1;
          want.req_kind = REQ_MEM;
          want.req_addr = ReqAddrW'({3'b000, it.packet_addr} * DataAlign);
          if (it.command == CMD_MEM_WRITE) begin
            want.req_data = it.data;
            want.req_write = 1'b1;
            answer = 1'b1;
          end else begin
            reply_seq = next_seq;
            awaiting_reply = 1'b1;
          end
        end else if (core == SYS_CORE_ID) begin
          ok = 1'b1;
          answer = 1'b1;
          with_data = 1'b1;
          if (regno == SYS_REG_CORES) begin
            word = DataW'(cores);
          end else if (regno == SYS_REG_MEM) begin
            word = DataW'(mem_mib);
          end else begin
            word = '1;
          end
        end else if (core >= RegNumW'(cores)) begin
          want.status = ST_BAD;
        end else begin
          ok = 1'b1;
          if (it.command == CMD_WRITE_CREG && regno == RegNumW'(ResetRegNum)) begin
            answer = 1'b1;
            with_data = 1'b1;
            word = DataW'(hold_reset);
            if (!it.data[0]) begin
              hold_reset = 1'b0;
            end
          end else if (regno == RegNumW'(HartIdRegNum)) begin
            answer = 1'b1;
            with_data = 1'b1;
            word = DataW'(1);
          end else begin
            want.req_kind = REQ_CREG;
            want.req_addr = ReqAddrW'(regno);
            if (it.command == CMD_WRITE_CREG) begin
              want.req_data = it.data;
              want.req_write = 1'b1;
            end
            reply_seq = next_seq;
            awaiting_reply = 1'b1;
          end
        end
        if (answer) begin
          want.ack_valid = 1'b1;
          want.ack_seq = next_seq;
          want.ack_has_data = with_data;
          want.ack_data = word;
        end
        if (ok) begin
          next_seq = next_seq + 8'd1;
        end
      end else if (it.opcode == OP_CREG_REPLY || it.opcode == OP_MEM_REPLY) begin
        if (awaiting_reply) begin
          want.ack_valid = 1'b1;
          want.ack_seq = reply_seq;
          want.ack_has_data = 1'b1;
          want.ack_data = it.data;
          awaiting_reply = 1'b0;
        end
      end else begin
        want.status = ST_BAD;
      end
      want.target_in_reset = hold_reset;
      due_results.push_back(want);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch at %0t:%s", $time, what);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      string   diff;
      if (due_results.size() == 0) begin
        flag($sformatf(" result with no item pending, got %h", got));
        return;
      end
      want = due_results.pop_front();
      diff = "";
      if (got.ack_valid !== want.ack_valid)
        diff = {diff, $sformatf(" ack_valid exp %h got %h", want.ack_valid, got.ack_valid)};
      if (got.ack_seq !== want.ack_seq)
        diff = {diff, $sformatf(" ack_seq exp %h got %h", want.ack_seq, got.ack_seq)};
      if (got.ack_has_data !== want.ack_has_data)
        diff = {diff, $sformatf(" ack_has_data exp %h got %h", want.ack_has_data,
                                got.ack_has_data)};
      if (got.ack_data !== want.ack_data)
        diff = {diff, $sformatf(" ack_data exp %h got %h", want.ack_data, got.ack_data)};
      if (got.req_kind !== want.req_kind)
        diff = {diff, $sformatf(" req_kind exp %h got %h", want.req_kind, got.req_kind)};
      if (got.req_addr !== want.req_addr)
        diff = {diff, $sformatf(" req_addr exp %h got %h", want.req_addr, got.req_addr)};
      if (got.req_data !== want.req_data)
        diff = {diff, $sformatf(" req_data exp %h got %h", want.req_data, got.req_data)};
      if (got.req_write !== want.req_write)
        diff = {diff, $sformatf(" req_write exp %h got %h", want.req_write, got.req_write)};
      if (got.target_in_reset !== want.target_in_reset)
        diff = {diff, $sformatf(" target_in_reset exp %h got %h", want.target_in_reset,
                                got.target_in_reset)};
      if (got.status !== want.status)
        diff = {diff, $sformatf(" status exp %h got %h", want.status, got.status)};
      if (diff != "") begin
        flag(diff);
      end
    endfunction
  endclass

  bridge_scoreboard sb = new();

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      sb.check_result({ack_valid, ack_seq, ack_has_data, ack_data, req_kind, req_addr,
                       req_data, req_write, target_in_reset, status});
    end
  end

  // result side: random stall before each result
  initial begin
    int pause;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      pause = steady ? 0 : int'($urandom_range(0, 19));
      if (pause != 0) begin
        result_stall = 1'b1;
        repeat (pause) @(negedge clk);
        result_stall = 1'b0;
      end
      do @(posedge clk); while (!result_valid);
    end
  end

  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_event(input item_t it);
    int gap;
    gap = steady ? 0 : int'($urandom_range(0, 19));
    @(negedge clk);
    if (gap != 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    {opcode, command, packet_seq, packet_size, packet_addr, data} = it;
    item_valid = 1'b1;
    do @(posedge clk); while (item_stall);
    sb.note_event(it);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(idx, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    item_valid = 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic item_t host_packet(logic [2:0] cmd, logic [AddrW-1:0] addr,
                                        logic [DataW-1:0] payload);
    item_t it;
    it = '0;
    it.opcode = OP_HOST;
    it.command = cmd;
    it.packet_seq = sb.next_seq;
    it.packet_size = ONE_DWORD;
    it.packet_addr = addr;
    it.data = payload;
    return it;
  endfunction

  function automatic item_t target_reply(logic [1:0] kind, logic [DataW-1:0] payload);
    item_t it;
    it = host_packet(3'($urandom), AddrW'({$urandom, $urandom}), payload);
    it.opcode = kind;
    it.packet_seq = 8'($urandom);
    return it;
  endfunction

  function automatic item_t random_event();
    item_t              it;
    int                 roll;
    int                 pick;
    logic [RegNumW-1:0] core;
    logic [RegNumW-1:0] regno;
    logic [1:0]         reply_kind;
    reply_kind = $urandom_range(0, 1) ? OP_CREG_REPLY : OP_MEM_REPLY;
    it = host_packet(3'($urandom_range(0, 3)), AddrW'({$urandom, $urandom}),
                     {$urandom, $urandom});
    roll = int'($urandom_range(0, 99));
    if (sb.awaiting_reply) begin
      if (roll < 70) begin
        it = target_reply(reply_kind, {$urandom, $urandom});
      end else if (roll >= 95) begin
        it.opcode = OpUndef;
      end
    end else if (roll < 80) begin
      if (it.command == CMD_READ_CREG || it.command == CMD_WRITE_CREG) begin
        pick = int'($urandom_range(0, 9));
        regno = RegNumW'($urandom);
        if (pick < 3) begin
          core = SYS_CORE_ID;
          case ($urandom_range(0, 2))
            0: regno = SYS_REG_CORES;
            1: regno = SYS_REG_MEM;
            default: ;
          endcase
        end else if (pick < 9) begin
          core = RegNumW'($urandom_range(0, sb.cores - 1));
          case ($urandom_range(0, 4))
            0: regno = RegNumW'(ResetRegNum);
            1: regno = RegNumW'(HartIdRegNum);
            default: ;
          endcase
        end else begin
          core = RegNumW'($urandom_range(sb.cores, 20'hFFFFE));
        end
        it.packet_addr = {core, regno};
      end
    end else if (roll < 85) begin
      it = target_reply(reply_kind, {$urandom, $urandom});
    end else begin
      case ($urandom_range(0, 4))
        0: it.packet_seq = sb.next_seq + 8'($urandom_range(1, 255));
        1: it.packet_size = SizeW'($urandom);
        2: it.command = 3'($urandom_range(CmdUnknown, CmdLast));
        3: it.opcode = OpUndef;
        default: begin
          it.opcode = 2'($urandom);
          it.command = 3'($urandom);
          it.packet_seq = 8'($urandom);
          it.packet_size = SizeW'($urandom);
        end
      endcase
    end
    return it;
  endfunction

  initial begin
    item_t            it;
    logic [CoreW-1:0] core_set;
    logic [MemW-1:0]  mem_set;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed items at reset configuration
    send_event(host_packet(CMD_MEM_READ, '0, '0));
    send_event(host_packet(CMD_MEM_WRITE, '1, '1));
    send_event(target_reply(OP_MEM_REPLY, '1));
    send_event(host_packet(CMD_MEM_WRITE, '1, '1));
    it = host_packet(CMD_MEM_WRITE, '0, '0);
    it.packet_seq = ~sb.next_seq;
    send_event(it);
    it = host_packet(CMD_MEM_WRITE, '0, '0);
    it.packet_size = '0;
    send_event(it);
    it.packet_size = '1;
    send_event(it);
    send_event(host_packet(CmdUnknown, '0, '0));
    send_event(host_packet(CmdLast, '1, '1));
    it = host_packet(CMD_MEM_READ, '0, '0);
    it.opcode = OpUndef;
    send_event(it);
    send_event(host_packet(CMD_READ_CREG, {SYS_CORE_ID, SYS_REG_CORES}, '0));
    send_event(host_packet(CMD_WRITE_CREG, {SYS_CORE_ID, SYS_REG_MEM}, '1));
    send_event(host_packet(CMD_READ_CREG, {SYS_CORE_ID, 20'hFFFFF}, '0));
    send_event(host_packet(CMD_READ_CREG, {20'd1, 20'd5}, '0));
    send_event(host_packet(CMD_WRITE_CREG, {20'd0, 20'(ResetRegNum)}, 64'd1));
    send_event(host_packet(CMD_READ_CREG, {20'd0, 20'(ResetRegNum)}, '0));
    send_event(target_reply(OP_CREG_REPLY, '0));
    send_event(host_packet(CMD_READ_CREG, {20'd0, 20'(HartIdRegNum)}, '0));
    send_event(host_packet(CMD_WRITE_CREG, {20'd0, 20'(HartIdRegNum)}, '1));
    send_event(host_packet(CMD_WRITE_CREG, {20'd0, 20'hFFFFF}, {$urandom, $urandom}));
    send_event(target_reply(OP_CREG_REPLY, {$urandom, $urandom}));
    send_event(target_reply(OP_MEM_REPLY, '1));
    send_event(host_packet(CMD_WRITE_CREG, {20'd0, 20'(ResetRegNum)}, 64'hFFFF_FFFF_FFFF_FFFE));
    send_event(host_packet(CMD_WRITE_CREG, {20'd0, 20'(ResetRegNum)}, 64'd1));

    for (int phase = 0; phase < 4; phase++) begin
      settle();
      case (phase)
        0: begin
          core_set = 5'd16;
          mem_set = 20'hFFFFF;
        end
        1: begin
          core_set = 5'd1;
          mem_set = '0;
        end
        default: begin
          core_set = 5'($urandom_range(1, 16));
          mem_set = MemW'($urandom_range(0, 20'hFFFFF));
        end
      endcase
      write_reg(REG_CORE_COUNT, 32'(core_set));
      write_reg(REG_MEM_SIZE, 32'(mem_set));
      steady = (phase == 2);
      repeat (270) send_event(random_event());
    end

    settle();
    if (sb.mismatches == 0 && sb.due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### files.f
hdl/htcb_pkg.sv
hdl/htcb_decode.sv
hdl/host_target_command_bridge_top.sv
sim/host_target_command_bridge_top_tb.sv
